@@ src/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// Square tone sequencer package
// Shared types, codes and constants for the tone sequencer and its divider.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Fixed field widths
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned INDEX_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Divider geometry: 32-bit dividend, 16-bit divisor, one quotient bit a step
  localparam int unsigned DIV_N_W   = 32;
  localparam int unsigned DIV_D_W   = 16;
  localparam int unsigned DIV_CNT_W = 6;

  // Configuration reset values
  localparam logic [AMP_W-1:0]  AMP_RESET      = 15'd3000;
  localparam logic [RATE_W-1:0] RATE_RESET     = 16'd22050;
  localparam logic [TICK_W-1:0] INTERVAL_RESET = 16'd151;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE = 2'd0,
    CFG_RATE      = 2'd1,
    CFG_INTERVAL  = 2'd2
  } cfg_index_t;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_PLAY   = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_RATE,
    ST_DIV_INDEX,
    ST_FINISH
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/sts_if.sv @@
// ----------------------------------------------------------------------------
// Square tone sequencer channels
// Valid/ready channels for input items and result samples.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  word_address;
  logic [15:0] word_value;
  logic [10:0] play_length;

  modport source (output valid, output kind, output word_address, output word_value,
                  output play_length, input ready);
  modport sink (input valid, input kind, input word_address, input word_value,
                input play_length, output ready);
endinterface

interface sts_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               is_playing;

  modport source (output valid, output sample_out, output is_playing, input ready);
  modport sink (input valid, input sample_out, input is_playing, output ready);
endinterface

@@ src/sts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/sts_div.sv @@
// ----------------------------------------------------------------------------
// Square tone sequencer divider
// Restoring divider, one quotient bit per cycle, 32 steps per division.
// ----------------------------------------------------------------------------
module sts_div (
  input  logic              clk,
  input  logic              rst,
  input  sts_pkg::div_req_t req,
  output sts_pkg::div_rsp_t rsp
);

  logic [sts_pkg::DIV_N_W-1:0]   quo;
  logic [sts_pkg::DIV_D_W-1:0]   rem;
  logic [sts_pkg::DIV_D_W-1:0]   divisor;
  logic [sts_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [sts_pkg::DIV_D_W:0]     shifted;
  logic [sts_pkg::DIV_D_W:0]     trial;
  logic                          fits;

  // Shift in the next dividend bit and try the subtraction
  assign shifted = {rem, quo[sts_pkg::DIV_N_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= sts_pkg::DIV_CNT_W'(sts_pkg::DIV_N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == sts_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[sts_pkg::DIV_N_W-2:0], fits};
      rem <= fits ? trial[sts_pkg::DIV_D_W-1:0] : shifted[sts_pkg::DIV_D_W-1:0];
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ src/square_tone_sequencer.sv @@
// ----------------------------------------------------------------------------
// Square tone sequencer
// Plays a stored frequency sequence as 16-bit square-wave audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per item: kind 1 loads word_value into the
//   sequence store at word_address, kind 2 starts playback of play_length
//   entries, kind 0 requests one sample. Kind 3 is dropped.
//   out_ch returns one transaction (sample_out, is_playing) per sample item.
//   cfg_we/cfg_index/cfg_data write amplitude (0), rate numerator (1) and step
//   interval (2); the user must write only while the block is idle (unenforced).
// Sample path:
//   Load and play items complete in the idle state. A sample with zero
//   frequency goes straight to the finishing step; otherwise it passes
//   through the shared 32-step divider (rate / frequency), and, unless the
//   half period is zero, through it again (sample index / half period).
//   in_ch.ready is high only between items.
// Reset: synchronous; restores the register defaults, stops playback, sets
//   the tick counter to one and clears the sample counter. The store is not
//   cleared.
// Stall: a finished sample waits in the output register; the next item is
//   accepted meanwhile, and a new sample waits until that register drains.
// ----------------------------------------------------------------------------
module square_tone_sequencer #(
  parameter int unsigned SEQ_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  sts_in_if.sink                             in_ch,
  sts_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned AW = $clog2(SEQ_DEPTH);
  localparam logic [16:0] DEPTH_W = 17'(SEQ_DEPTH);

  sts_pkg::state_t state;
  sts_pkg::state_t state_next;

  // Configuration registers
  logic [sts_pkg::AMP_W-1:0]  tone_amplitude;
  logic [sts_pkg::RATE_W-1:0] rate_numerator;
  logic [sts_pkg::TICK_W-1:0] step_interval;

  // Playback state
  logic [sts_pkg::LEN_W-1:0]   sequence_length;
  logic [sts_pkg::POS_W-1:0]   sequence_position;
  logic                        playing;
  logic [sts_pkg::FREQ_W-1:0]  current_frequency;
  logic [sts_pkg::INDEX_W-1:0] sample_index;
  logic [sts_pkg::TICK_W-1:0]  step_ticks;
  logic [sts_pkg::SAMPLE_W-1:0] sample;

  // Output register
  logic                         out_valid;
  logic [sts_pkg::SAMPLE_W-1:0] out_sample;
  logic                         out_playing;

  logic                         in_ready;
  logic                         accept;
  logic                         advance;
  logic [sts_pkg::AMP_W-1:0]    half;
  logic [sts_pkg::TICK_W-1:0]   ticks_inc;
  logic                         fetch;
  logic                         exhausted;
  logic                         playing_after;
  logic                         store_we;
  logic [sts_pkg::FREQ_W-1:0]   store_rd_data;
  logic [sts_pkg::LEN_W-1:0]    length_sat;

  sts_pkg::div_req_t div_req;
  sts_pkg::div_rsp_t div_rsp;

  assign accept  = in_ch.valid && in_ready;
  assign advance = (state == sts_pkg::ST_FINISH) && (!out_valid || out_ch.ready);
  assign half    = div_rsp.quotient[sts_pkg::AMP_W:1];

  // Tick advance and sequence fetch decision
  assign ticks_inc = step_ticks + 1'b1;
  assign fetch     = ticks_inc > step_interval;
  assign exhausted = (sequence_position >= {5'd0, sequence_length}) ||
                     ({1'b0, sequence_position} >= DEPTH_W);
  assign playing_after = (fetch && playing && exhausted) ? 1'b0 : playing;

  // Clamp play length to the store depth
  assign length_sat = ({6'd0, in_ch.play_length} > DEPTH_W) ? DEPTH_W[sts_pkg::LEN_W-1:0]
                                                           : in_ch.play_length;

  // Sequence store
  assign store_we = accept && (in_ch.kind == sts_pkg::KIND_LOAD) &&
                    ({7'd0, in_ch.word_address} < DEPTH_W);

  sts_ram #(
    .WIDTH (sts_pkg::FREQ_W),
    .DEPTH (SEQ_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .wr_addr (AW'(in_ch.word_address)),
    .wr_data (in_ch.word_value),
    .rd_addr (sequence_position[AW-1:0]),
    .rd_data (store_rd_data)
  );

  // Shared divider
  sts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and divider requests
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_req    = '0;
    case (state)
      sts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid && (in_ch.kind == sts_pkg::KIND_SAMPLE)) begin
          if (current_frequency == '0) begin
            state_next = sts_pkg::ST_FINISH;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = {16'd0, rate_numerator};
            div_req.divisor  = current_frequency;
            state_next       = sts_pkg::ST_DIV_RATE;
          end
        end
      end
      sts_pkg::ST_DIV_RATE: begin
        if (div_rsp.done) begin
          if (half == '0) begin
            state_next = sts_pkg::ST_FINISH;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = sample_index;
            div_req.divisor  = {1'b0, half};
            state_next       = sts_pkg::ST_DIV_INDEX;
          end
        end
      end
      sts_pkg::ST_DIV_INDEX: begin
        if (div_rsp.done) begin
          state_next = sts_pkg::ST_FINISH;
        end
      end
      sts_pkg::ST_FINISH: begin
        if (!out_valid || out_ch.ready) begin
          state_next = sts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_amplitude    <= sts_pkg::AMP_RESET;
      rate_numerator    <= sts_pkg::RATE_RESET;
      step_interval     <= sts_pkg::INTERVAL_RESET;
      sequence_length   <= '0;
      sequence_position <= '0;
      playing           <= 1'b0;
      current_frequency <= '0;
      sample_index      <= '0;
      step_ticks        <= sts_pkg::TICK_W'(1);
      out_valid         <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          sts_pkg::CFG_AMPLITUDE: tone_amplitude <= cfg_data[sts_pkg::AMP_W-1:0];
          sts_pkg::CFG_RATE:      rate_numerator <= cfg_data;
          sts_pkg::CFG_INTERVAL:  step_interval  <= cfg_data;
          default: begin
          end
        endcase
      end

      // Load a new result, or drop the old one once taken
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      // Start playback from the first entry
      if (accept && (in_ch.kind == sts_pkg::KIND_PLAY)) begin
        sequence_length   <= length_sat;
        sequence_position <= '0;
        playing           <= 1'b1;
      end

      // Advance counters and sequence with the published sample
      if (advance) begin
        sample_index <= sample_index + 1'b1;
        step_ticks   <= fetch ? '0 : ticks_inc;
        if (fetch && playing) begin
          sequence_position <= sequence_position + 1'b1;
          if (exhausted) begin
            playing           <= 1'b0;
            current_frequency <= '0;
          end else begin
            current_frequency <= store_rd_data;
          end
        end
      end
    end
  end

  // Sample value and output payload
  always_ff @(posedge clk) begin
    case (state)
      sts_pkg::ST_IDLE: begin
        if (accept) begin
          sample <= '0;
        end
      end
      sts_pkg::ST_DIV_RATE: begin
        if (div_rsp.done && (half == '0)) begin
          sample <= '0;
        end
      end
      sts_pkg::ST_DIV_INDEX: begin
        if (div_rsp.done) begin
          sample <= div_rsp.quotient[0] ? {1'b0, tone_amplitude}
                                        : (16'd0 - {1'b0, tone_amplitude});
        end
      end
      default: begin
      end
    endcase
    if (advance) begin
      out_sample  <= sample;
      out_playing <= playing_after;
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = $signed(out_sample);
  assign out_ch.is_playing = out_playing;

  // Divider is never restarted while a division is in flight
  a_div_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A new result appears only after the finishing step
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == sts_pkg::ST_FINISH))
    else $error("result published outside the finishing step");

  // Playback stops only at a sequence fetch
  a_stop_on_fetch: assert property (@(posedge clk) disable iff (rst)
    $fell(playing) |-> $past(advance && fetch))
    else $error("playback stopped without a fetch");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Square tone sequencer testbench
// Drives register writes and load, start, sample and unused-kind items with
// random gaps and output stalls, predicts every sample with a cycle-free
// model of the sequencer and compares each sample and playing flag in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int SEQ_DEPTH     = 1024;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [15:0] level;
    logic               playing;
  } tone_sample_t;

  // One row of the directed script: a register write or an input item
  typedef struct packed {
    logic                is_cfg;
    sts_pkg::cfg_index_t reg_idx;
    logic [15:0]         reg_data;
    logic [1:0]          kind;
    logic [9:0]          addr;
    logic [15:0]         value;
    logic [10:0]         len;
    logic                typed;
    logic signed [15:0]  exp_level;
    logic                exp_play;
  } step_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [sts_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sts_pkg::CFG_DATA_W-1:0] cfg_data;

  sts_in_if  in_ch ();
  sts_out_if out_ch ();

  square_tone_sequencer #(.SEQ_DEPTH(SEQ_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model of the sequencer registers and playback state
  logic [sts_pkg::AMP_W-1:0]  amp_reg      = sts_pkg::AMP_RESET;
  logic [sts_pkg::RATE_W-1:0] rate_reg     = sts_pkg::RATE_RESET;
  logic [sts_pkg::TICK_W-1:0] interval_reg = sts_pkg::INTERVAL_RESET;
  logic [15:0]       tone_store [SEQ_DEPTH];
  bit [SEQ_DEPTH-1:0] store_written = '0;
  logic [10:0]       play_len   = '0;
  logic [15:0]       play_pos   = '0;
  logic              play_on    = 1'b0;
  logic [15:0]       cur_freq   = '0;
  logic [31:0]       smp_count  = '0;
  logic [15:0]       step_ctr   = 16'd1;

  tone_sample_t tone_exp_q [$];

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int errors     = 0;
  int items_sent = 0;
  int n_samples  = 0;
  int n_loads    = 0;
  int n_plays    = 0;
  int n_dropped  = 0;
  int n_checked  = 0;
  int n_settings = 0;
  int idle_cycles = 0;

  // Directed script: reset state, every item kind, register extremes,
  // silence, zero half period, positive and negative levels, restart
  step_row_t script [28] = '{
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b1, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, KIND_UNUSED, 10'h3FF, 16'hFFFF, 11'h7FF,
      1'b0, 16'sd0, 1'b0},
    '{1'b1, sts_pkg::CFG_INTERVAL, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_LOAD, 10'd0, 16'd1, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_LOAD, 10'd1, 16'hFFFF, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_LOAD, 10'd2, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_LOAD, 10'h3FF, 16'hFFFF, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_LOAD, 10'd3, 16'd11025, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_PLAY, 10'd0, 16'd0, 11'd4,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b1, 16'sd0, 1'b1},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b1, -16'sd3000, 1'b1},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b1, 16'sd0, 1'b1},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b1, sts_pkg::CFG_AMPLITUDE, 16'd32767, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b1, sts_pkg::CFG_RATE, 16'd65535, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_LOAD, 10'd0, 16'd2, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_PLAY, 10'd0, 16'd0, 11'h7FF,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b1, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b1, sts_pkg::CFG_RATE, 16'd1, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b1, sts_pkg::CFG_INTERVAL, 16'd65535, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0},
    '{1'b0, sts_pkg::CFG_AMPLITUDE, 16'd0, sts_pkg::KIND_SAMPLE, 10'd0, 16'd0, 11'd0,
      1'b0, 16'sd0, 1'b0}
  };

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void flag(input string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endfunction

  // Produce the next square-wave sample and advance ticks and playback
  function automatic tone_sample_t next_sample();
    tone_sample_t s;
    logic [15:0] half;
    s.level = 16'sd0;
    if (cur_freq != 0) begin
      half = 16'((rate_reg / cur_freq) >> 1);
      if (half != 0) begin
        if (((smp_count / half) & 32'd1) != 0) s.level = $signed({1'b0, amp_reg});
        else s.level = -$signed({1'b0, amp_reg});
      end
    end
    smp_count = smp_count + 32'd1;
    step_ctr  = step_ctr + 16'd1;
    if (step_ctr > interval_reg) begin
      step_ctr = '0;
      if (play_on) begin
        cur_freq = '0;
        if (play_pos >= play_len || play_pos >= SEQ_DEPTH) play_on = 1'b0;
        else cur_freq = tone_store[play_pos[9:0]];
        play_pos = play_pos + 16'd1;
      end
    end
    s.playing = play_on;
    return s;
  endfunction

  // True when the next sample would fetch a store entry never written
  function automatic bit fetch_hits_hole(output logic [9:0] hole);
    logic [15:0] tick_next;
    tick_next = step_ctr + 16'd1;
    hole = play_pos[9:0];
    return play_on && tick_next > interval_reg && play_pos < play_len &&
           play_pos < SEQ_DEPTH && !store_written[play_pos[9:0]];
  endfunction

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'($urandom);
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  // Send one input transaction and record what it should produce
  task automatic send_item(input logic [1:0] kind, input logic [9:0] addr,
                           input logic [15:0] value, input logic [10:0] len,
                           input bit typed = 1'b0,
                           input logic signed [15:0] typed_level = 16'sd0,
                           input bit typed_play = 1'b0);
    int gap;
    logic [9:0] hole;
    tone_sample_t want;
    // fill the entry that this sample is about to fetch
    if (kind == sts_pkg::KIND_SAMPLE && fetch_hits_hole(hole))
      send_item(sts_pkg::KIND_LOAD, hole, pick_freq(), 11'($urandom));
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind         = kind;
    in_ch.word_address = addr;
    in_ch.word_value   = value;
    in_ch.play_length  = len;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    case (kind)
      sts_pkg::KIND_LOAD: begin
        tone_store[addr]    = value;
        store_written[addr] = 1'b1;
        n_loads++;
      end
      sts_pkg::KIND_PLAY: begin
        play_len = (len > SEQ_DEPTH) ? 11'(SEQ_DEPTH) : len;
        play_pos = '0;
        play_on  = 1'b1;
        n_plays++;
      end
      sts_pkg::KIND_SAMPLE: begin
        want = next_sample();
        if (typed) begin
          want.level   = typed_level;
          want.playing = typed_play;
        end
        tone_exp_q.push_back(want);
        n_samples++;
      end
      default: n_dropped++;
    endcase
    items_sent++;
  endtask

  // Hold the input idle until every sample is back and the block is quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tone_exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input sts_pkg::cfg_index_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      sts_pkg::CFG_AMPLITUDE: amp_reg      = data[sts_pkg::AMP_W-1:0];
      sts_pkg::CFG_RATE:      rate_reg     = data;
      sts_pkg::CFG_INTERVAL:  interval_reg = data;
      default: ;
    endcase
  endtask

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", idle_cycles);
      $display("square_tone_sequencer test failed");
      $finish;
    end
  end

  // Accept samples with random stalls and check them in order
  initial begin : sample_sink
    int stall;
    tone_sample_t want;
    out_ch.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      stall = stalls_on ? $urandom_range(0, 3) : 0;
      out_ch.ready = (stall == 0);
      if (stall != 0) begin
        repeat (stall) @(negedge clk);
        out_ch.ready = 1'b1;
      end
      do @(posedge clk); while (!out_ch.valid);
      n_checked++;
      if (tone_exp_q.size() == 0) begin
        flag($sformatf("unexpected sample %0d playing %0b",
                       out_ch.sample_out, out_ch.is_playing));
      end else begin
        want = tone_exp_q.pop_front();
        if (out_ch.sample_out !== want.level || out_ch.is_playing !== want.playing)
          flag($sformatf("sample %0d: expected %0d playing %0b, got %0d playing %0b",
                         n_checked, want.level, want.playing,
                         out_ch.sample_out, out_ch.is_playing));
      end
      @(negedge clk);
    end
  end

  // Reset, directed script, random phases, final verdict
  initial begin : stimulus
    int pick;
    int span;
    int random_goal;
    int phase_end;
    logic [10:0] len;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = sts_pkg::CFG_AMPLITUDE;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = sts_pkg::KIND_SAMPLE;
    in_ch.word_address = '0;
    in_ch.word_value   = '0;
    in_ch.play_length  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // walk the directed script
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        cfg_write(script[i].reg_idx, script[i].reg_data);
      end else begin
        send_item(script[i].kind, script[i].addr, script[i].value, script[i].len,
                  script[i].typed, script[i].exp_level, script[i].exp_play);
      end
    end

    // random phases, each under a fresh register setting
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      settle();
      case ($urandom_range(0, 3))
        0:       cfg_write(sts_pkg::CFG_AMPLITUDE, 16'd0);
        1:       cfg_write(sts_pkg::CFG_AMPLITUDE, 16'd32767);
        default: cfg_write(sts_pkg::CFG_AMPLITUDE, 16'($urandom_range(0, 32767)));
      endcase
      case ($urandom_range(0, 4))
        0:       cfg_write(sts_pkg::CFG_RATE, 16'd1);
        1:       cfg_write(sts_pkg::CFG_RATE, 16'hFFFF);
        2:       cfg_write(sts_pkg::CFG_RATE, sts_pkg::RATE_RESET);
        default: cfg_write(sts_pkg::CFG_RATE, 16'($urandom_range(1, 65535)));
      endcase
      case ($urandom_range(0, 7))
        0:          cfg_write(sts_pkg::CFG_INTERVAL, 16'd0);
        1:          cfg_write(sts_pkg::CFG_INTERVAL, 16'hFFFF);
        2:          cfg_write(sts_pkg::CFG_INTERVAL, 16'($urandom));
        3, 4, 5:    cfg_write(sts_pkg::CFG_INTERVAL, 16'($urandom_range(0, 7)));
        default:    cfg_write(sts_pkg::CFG_INTERVAL, 16'($urandom_range(0, 3)));
      endcase
      n_settings++;
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      phase_end = items_sent + $urandom_range(100, 250);

      while (items_sent < phase_end && items_sent < random_goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // load a short sequence from entry 0, start it, then play it out
          span = $urandom_range(1, 12);
          for (int i = 0; i < span; i++)
            send_item(sts_pkg::KIND_LOAD, 10'(i), pick_freq(), 11'($urandom));
          len = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'(span);
          send_item(sts_pkg::KIND_PLAY, 10'($urandom), 16'($urandom), len);
          repeat ($urandom_range(4, 40))
            send_item(sts_pkg::KIND_SAMPLE, 10'($urandom), 16'($urandom), 11'($urandom));
        end else if (pick < 72) begin
          repeat ($urandom_range(1, 20))
            send_item(sts_pkg::KIND_SAMPLE, 10'($urandom), 16'($urandom), 11'($urandom));
        end else if (pick < 85) begin
          send_item(sts_pkg::KIND_LOAD, 10'($urandom), 16'($urandom), 11'($urandom));
        end else if (pick < 93) begin
          send_item(sts_pkg::KIND_PLAY, 10'($urandom), 16'($urandom), 11'($urandom));
        end else if (pick < 97) begin
          send_item(KIND_UNUSED, 10'($urandom), 16'($urandom), 11'($urandom));
        end else begin
          case ($urandom_range(0, 2))
            0:       len = 11'd0;
            1:       len = 11'(SEQ_DEPTH);
            default: len = 11'h7FF;
          endcase
          send_item(sts_pkg::KIND_PLAY, 10'($urandom), 16'($urandom), len);
        end
      end
    end

    settle();
    if (tone_exp_q.size() != 0)
      flag($sformatf("%0d samples never returned", tone_exp_q.size()));
    $display("Ran %0d samples, %0d store loads, %0d playback starts, %0d dropped items",
             n_samples, n_loads, n_plays, n_dropped);
    $display("over %0d random register settings; %0d samples checked, %0d errors",
             n_settings, n_checked, errors);
    if (errors == 0)
      $display("square_tone_sequencer test passed");
    else
      $display("square_tone_sequencer test failed");
    $finish;
  end

endmodule
